// ===== hdl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, types and functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BlockBytes = 64;
	localparam int PosW       = 6;
	localparam int Rounds     = 64;
	localparam int RoundW     = 6;
	localparam int WordW      = 32;
	localparam int LenW       = 64;
	localparam int DigestWords = 8;
	localparam int IdxW       = 3;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [PosW-1:0] LenPos = 6'd56;

	localparam logic [WordW-1:0] IV [DigestWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WordW-1:0] RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef logic [WordW-1:0] word_t;

	// Beat layouts of the input and output channels.
	typedef struct packed {
		logic [7:0] message_byte;
		logic       has_byte;
		logic       last_item;
	} in_beat_t;

	typedef struct packed {
		logic [WordW-1:0] digest_word;
		logic [IdxW-1:0]  word_pos;
		logic             last_word;
	} digest_beat_t;

	// Controller to datapath.
	typedef struct packed {
		logic       wr_byte;   // write byte_val at byte_pos
		logic [7:0] byte_val;
		logic [PosW-1:0] byte_pos;
		logic       add_len;   // bit count += 8
		logic       clr_len;   // bit count = 0
		logic       start;     // load schedule and working words
		logic       round;     // run one round at round index
		logic [RoundW-1:0] round_idx;
		logic       fold;      // chain += working words
		logic       reload;    // chain = IV
		logic [IdxW-1:0] out_idx;
	} sha_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [LenW-1:0] bit_len;
	} sha_stat_t;

	function automatic word_t ror(input word_t x, input int n);
		ror = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic logic [7:0] len_byte(input logic [LenW-1:0] len,
			input logic [2:0] k);
		logic [5:0] sh;
		sh = {3'd7 - k, 3'd0};
		len_byte = 8'(len >> sh);
	endfunction

endpackage

// ===== hdl/sha_stream_if.sv =====
// ----------------------------------------------------------------------------
// sha_stream_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
interface sha_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module sha_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, bit count, message schedule, round unit and chaining words.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_pkg::sha_cmd_t   cmd,
	output sha_pkg::sha_stat_t  stat,
	output sha_pkg::word_t      digest
);
	sha_pkg::word_t chain_q [sha_pkg::DigestWords];
	sha_pkg::word_t v_q [sha_pkg::DigestWords];
	sha_pkg::word_t w_q [16];
	logic [sha_pkg::LenW-1:0] len_q;
	logic [sha_pkg::PosW-1:0] raddr;
	logic [7:0] rdata;

	// The buffer is read one byte per cycle during the start phase: the
	// controller issues byte addresses and the schedule shifts bytes in.
	assign raddr = cmd.byte_pos;

	sha_ram #(.Width(8), .Depth(sha_pkg::BlockBytes)) u_buf (
		.clk(clk), .we(cmd.wr_byte), .waddr(cmd.byte_pos), .wdata(cmd.byte_val),
		.raddr(raddr), .rdata(rdata)
	);

	sha_pkg::word_t s0, s1, wnew, w_cur, t1, t2, e, a;

	always_comb begin
		s0 = sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		w_cur = (cmd.round_idx < 6'd16) ? w_q[0] : wnew;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::RoundK[cmd.round_idx] + w_cur;
		t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// During start, the byte read last cycle is shifted into the schedule
	// tail; after 64 bytes w_q[0] holds word 0.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], rdata};
			for (int k = 0; k < sha_pkg::DigestWords; k++) begin
				v_q[k] <= chain_q[k];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_cur;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int k = 0; k < sha_pkg::DigestWords; k++) begin
				chain_q[k] <= sha_pkg::IV[k];
			end
		end else begin
			if (cmd.clr_len) begin
				len_q <= '0;
			end else if (cmd.add_len) begin
				len_q <= len_q + 64'd8;
			end
			if (cmd.reload) begin
				for (int k = 0; k < sha_pkg::DigestWords; k++) begin
					chain_q[k] <= sha_pkg::IV[k];
				end
			end else if (cmd.fold) begin
				for (int k = 0; k < sha_pkg::DigestWords; k++) begin
					chain_q[k] <= chain_q[k] + v_q[k];
				end
			end
		end
	end

	assign stat.bit_len = len_q;
	assign digest = chain_q[cmd.out_idx];
endmodule

// ===== hdl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, block loads, rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               in_has,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_idx,
	output sha_pkg::sha_cmd_t  cmd,
	input  sha_pkg::sha_stat_t stat
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1; // write pad / zero / length bytes
	localparam logic [2:0] S_LOAD  = 3'd2; // read 64 bytes into schedule
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_FOLD  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [6:0] cnt_q;        // load counter runs to 64 inclusive
	logic [5:0] rnd_q;
	logic [5:0] pad_pos_q;
	logic       fin_q;        // in finish sequence
	logic       second_q;     // set once the first finish block is padded
	logic [sha_pkg::LenW-1:0] len_q;
	logic [2:0] oidx_q;
	logic [5:0] pos;

	assign pos = stat.bit_len[8:3];
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_idx = oidx_q;

	// Padding byte at a position of the final or pre-final block. The length
	// goes into the second of two finish blocks, or into the only one when
	// the pad marker lands ahead of the length field.
	logic [7:0] pad_val;
	logic       len_blk;
	assign len_blk = second_q || (len_q[8:3] < sha_pkg::LenPos);
	always_comb begin
		if (pad_pos_q == len_q[8:3] && !second_q) begin
			pad_val = sha_pkg::PadByte;
		end else if (pad_pos_q >= sha_pkg::LenPos && len_blk) begin
			pad_val = sha_pkg::len_byte(len_q, pad_pos_q[2:0]);
		end else begin
			pad_val = 8'h00;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.out_idx = oidx_q;
		cmd.round_idx = rnd_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.byte_pos = pos;
				cmd.byte_val = in_byte;
				if (in_valid && in_has) begin
					cmd.wr_byte = 1'b1;
					cmd.add_len = 1'b1;
				end
			end
			S_PAD: begin
				cmd.byte_pos = pad_pos_q;
				cmd.byte_val = pad_val;
				cmd.wr_byte = 1'b1;
			end
			S_LOAD: begin
				cmd.byte_pos = cnt_q[5:0];
				cmd.start = (cnt_q != 7'd0);
			end
			S_ROUND: cmd.round = 1'b1;
			S_FOLD: cmd.fold = 1'b1;
			S_OUT: begin
				if (out_ready && oidx_q == 3'd7) begin
					cmd.reload = 1'b1;
					cmd.clr_len = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rnd_q <= '0;
			pad_pos_q <= '0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			len_q <= '0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_last) begin
							// Length after this beat's byte.
							len_q <= stat.bit_len + (in_has ? 64'd8 : 64'd0);
							fin_q <= 1'b1;
							second_q <= 1'b0;
							state_q <= S_PAD;
							pad_pos_q <= pos + (in_has ? 6'd1 : 6'd0);
							if (in_has && pos == 6'd63) begin
								// Buffer just filled: compress it first.
								state_q <= S_LOAD;
								cnt_q <= '0;
								pad_pos_q <= '0;
							end
						end else if (in_has && pos == 6'd63) begin
							fin_q <= 1'b0;
							state_q <= S_LOAD;
							cnt_q <= '0;
						end
					end
				end
				S_PAD: begin
					pad_pos_q <= pad_pos_q + 6'd1;
					if (pad_pos_q == 6'd63) begin
						state_q <= S_LOAD;
						cnt_q <= '0;
						// Pad marker at 56 or later leaves no room for length.
						if (!second_q && len_q[8:3] >= sha_pkg::LenPos) begin
							second_q <= 1'b1;
						end else begin
							second_q <= 1'b1;
							fin_q <= 1'b0;
						end
						if (!second_q && len_q[8:3] >= sha_pkg::LenPos) begin
							fin_q <= 1'b1;
						end
					end
				end
				S_LOAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64) begin
						state_q <= S_ROUND;
						rnd_q <= '0;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (fin_q) begin
						// Another finish block follows.
						state_q <= S_PAD;
						pad_pos_q <= second_q ? 6'd0 : len_q[8:3];
					end else if (second_q) begin
						state_q <= S_OUT;
						oidx_q <= '0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= S_IDLE;
							second_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256 engine with padding and eight-word digest output.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  in_ch     in   message_byte[8], has_byte, last_item
//  out_ch    out  digest_word[32], word_pos[3], last_word
//
// A plain byte beat goes straight into the buffer; the beat that fills a block
// adds a compression (buffer reads, 64 rounds, one fold), paced by the single
// round unit and the one-byte read port of the block buffer. A last beat runs
// padding (up to 64 writes) and one or two such compressions, then eight
// output beats. Reset loads the initial hash value and clears the bit count.
// The output waits for ready and holds the word; input is not taken meanwhile.
module sha256_stream_hasher (
	input logic clk,
	input logic arst_n,
	sha_stream_if.sink   in_ch,
	sha_stream_if.source out_ch
);
	sha_pkg::sha_cmd_t  cmd;
	sha_pkg::sha_stat_t stat;
	sha_pkg::word_t     digest;
	logic [2:0]         idx;

	// The controller sequences intake, padding, loading and rounds.
	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_byte(in_ch.data.message_byte), .in_has(in_ch.data.has_byte),
		.in_last(in_ch.data.last_item),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_idx(idx),
		.cmd(cmd), .stat(stat)
	);

	// The datapath holds all message state and the round logic.
	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .digest(digest)
	);

	// Output words come straight from the chaining registers, which hold
	// steady until the last word is taken.
	assign out_ch.data.digest_word = digest;
	assign out_ch.data.word_pos    = idx;
	assign out_ch.data.last_word   = (idx == 3'd7);
endmodule

// ===== sim/sha256_stream_hasher_tb.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking testbench for the byte-stream SHA-256 hasher. It sends
// messages one byte per beat and runs its own SHA-256 model on every
// accepted beat. Each digest word that comes out is checked against the
// oldest predicted word. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 20000;   // cycles without any accepted beat on either channel
	localparam int DrainCycles = 400;   // quiet time after the last digest word

	logic clk;
	logic arst_n;

	sha_stream_if #(.payload_t(sha_pkg::in_beat_t))     in_ch ();
	sha_stream_if #(.payload_t(sha_pkg::digest_beat_t)) out_ch ();

	sha256_stream_hasher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// 8 ns clock.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// ------------------------------------------------------------------
	// Hash model: chaining words, block buffer and bit count, updated on
	// every accepted input beat exactly as the hardware should.
	// ------------------------------------------------------------------
	logic [31:0]  chain_hash [8];
	logic [7:0]   msg_block [64];
	logic [63:0]  msg_bits;
	sha_pkg::digest_beat_t digest_queue [$];
	int           error_count;

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of msg_block into chain_hash.
	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] w2, w15, t1, t2;
		int s;
		for (int t = 0; t < 16; t++) begin
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		end
		for (int k = 0; k < 8; k++) begin
			v[k] = chain_hash[k];
		end
		for (int t = 0; t < 64; t++) begin
			s = t % 16;
			if (t >= 16) begin
				w2  = w[(t - 2) % 16];
				w15 = w[(t - 15) % 16];
				w[s] = (rotr32(w2, 17) ^ rotr32(w2, 19) ^ (w2 >> 10)) + w[(t - 7) % 16]
					+ (rotr32(w15, 7) ^ rotr32(w15, 18) ^ (w15 >> 3)) + w[s];
			end
			t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[s];
			t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++) begin
			chain_hash[k] += v[k];
		end
	endtask

	// Takes one accepted beat; a last beat pads, finishes and queues the digest.
	task automatic absorb_beat(input sha_pkg::in_beat_t b);
		int pos;
		logic [63:0] len;
		sha_pkg::digest_beat_t d;
		if (b.has_byte) begin
			pos = int'(msg_bits[8:3]);
			msg_block[pos] = b.message_byte;
			msg_bits += 64'd8;
			if (pos == 63) begin
				compress_block();
			end
		end
		if (!b.last_item) begin
			return;
		end
		len = msg_bits;
		pos = int'(len[8:3]);
		msg_block[pos] = sha_pkg::PadByte;
		for (int k = pos + 1; k < 64; k++) begin
			msg_block[k] = 8'h00;
		end
		// No room left for the length: it goes into an extra block.
		if (pos >= 56) begin
			compress_block();
			for (int k = 0; k < 64; k++) begin
				msg_block[k] = 8'h00;
			end
		end
		for (int k = 0; k < 8; k++) begin
			msg_block[56 + k] = len[63 - 8*k -: 8];
		end
		compress_block();
		for (int k = 0; k < 8; k++) begin
			d.digest_word = chain_hash[k];
			d.word_pos    = 3'(k);
			d.last_word   = (k == 7);
			digest_queue.push_back(d);
		end
		// The hardware reloads the initial value on its own for the next message.
		for (int k = 0; k < 8; k++) begin
			chain_hash[k] = sha_pkg::IV[k];
		end
		msg_bits = '0;
	endtask

	// ------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge. Input beats feed
	// the model, output beats are checked against the oldest prediction.
	// The watchdog ends the run when nothing moves for too long.
	// ------------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk) begin
		sha_pkg::digest_beat_t want;
		logic moved;
		if (arst_n) begin
			moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (in_ch.valid && in_ch.ready) begin
				absorb_beat(in_ch.data);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest beat %h", $realtime, out_ch.data);
					error_count++;
				end else begin
					want = digest_queue.pop_front();
					if (out_ch.data.digest_word !== want.digest_word) begin
						$display("%0t: digest_word expected %h actual %h", $realtime,
							want.digest_word, out_ch.data.digest_word);
						error_count++;
					end
					if (out_ch.data.word_pos !== want.word_pos) begin
						$display("%0t: word_pos expected %0d actual %0d", $realtime,
							want.word_pos, out_ch.data.word_pos);
						error_count++;
					end
					if (out_ch.data.last_word !== want.last_word) begin
						$display("%0t: last_word expected %b actual %b", $realtime,
							want.last_word, out_ch.data.last_word);
						error_count++;
					end
				end
			end
			if (idle_cycles >= IdleLimit) begin
				$display("%0t: watchdog expired, %0d digest words still due", $realtime,
					digest_queue.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready changes at the falling edge. Its behavior is redrawn at
	// random, whenever its tick counter wraps, between always ready, a coin toss
	// per cycle and long stalls, so stalls land on every digest word position.
	// ------------------------------------------------------------------
	int stall_mode;
	int stall_tick;

	always @(negedge clk) begin
		if (stall_tick == 0) begin
			stall_mode = $urandom_range(0, 2);
		end
		stall_tick = (stall_tick + 1) % 64;
		case (stall_mode)
			0: begin
				out_ch.ready <= 1'b1;
			end
			1: begin
				out_ch.ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ch.ready <= ($urandom_range(0, 9) == 0);
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sender: beats go out in bursts of random length with random gaps
	// in between. Valid only drops when a gap actually starts.
	// ------------------------------------------------------------------
	int burst_left;

	task automatic send_beat(input logic [7:0] data_byte, input logic with_byte,
			input logic is_last);
		sha_pkg::in_beat_t b;
		int gap;
		b.message_byte = data_byte;
		b.has_byte     = with_byte;
		b.last_item    = is_last;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data  <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic pause_sender();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Sends a whole message of random bytes; the last beat either carries
	// the final byte or comes on its own with no byte.
	task automatic send_message(input int length, output int beats);
		bit last_carries;
		beats = 0;
		last_carries = (length > 0) && $urandom_range(0, 1);
		for (int i = 0; i < length; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				beats++;
			end
			send_beat(8'($urandom_range(0, 255)), 1'b1,
				last_carries && (i == length - 1));
			beats++;
		end
		if (!last_carries) begin
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			beats++;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Empty messages: two last beats with no byte each give the hash of nothing.
	task automatic test_empty_message();
		send_beat(8'hA5, 1'b0, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);
	endtask

	// Idle beats carry no byte and must not disturb the message around them.
	task automatic test_idle_beats();
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
	endtask

	// Byte extremes, both on the closing beat and ahead of an empty close.
	task automatic test_byte_extremes();
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h7F, 1'b1, 1'b0);
		send_beat(8'h55, 1'b0, 1'b1);
		send_beat(8'hAA, 1'b1, 1'b0);
		send_beat(8'h01, 1'b1, 1'b1);
	endtask

	// Random messages: mostly short, with lengths around the padding limit,
	// the block boundary and the padding limit of the second block mixed in.
	task automatic test_random_messages();
		int sent;
		int length;
		int beats;
		sent = 0;
		while (sent < 140) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					length = $urandom_range(0, 10);
				end
				6: begin
					length = $urandom_range(55, 57);
				end
				7: begin
					length = $urandom_range(63, 65);
				end
				8: begin
					length = $urandom_range(119, 121);
				end
				default: begin
					length = $urandom_range(11, 130);
				end
			endcase
			send_message(length, beats);
			sent += beats;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		error_count  = 0;
		idle_cycles  = 0;
		burst_left   = 0;
		stall_tick   = 0;
		stall_mode   = 0;
		msg_bits     = '0;
		for (int k = 0; k < 8; k++) begin
			chain_hash[k] = sha_pkg::IV[k];
		end
		for (int k = 0; k < 64; k++) begin
			msg_block[k] = 8'h00;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_message();
		test_idle_beats();
		test_byte_extremes();
		test_random_messages();
		pause_sender();

		// Let the last digests drain; the watchdog covers a stuck block.
		while (digest_queue.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
